// ----- sv/hhpe_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP target extractor package
// Shared types, constants and helper functions of the target extractor.
// ----------------------------------------------------------------------------
package hhpe_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam int unsigned CfgAddrW = 2;
  localparam logic [CfgAddrW-1:0] CfgTunnelPort = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgPlainPort  = 2'd1;

  localparam logic [15:0] TunnelPortReset = 16'd443;
  localparam logic [15:0] PlainPortReset  = 16'd80;

  localparam logic [47:0] HostTag      = 48'h0D0A_486F_7374;
  localparam logic [3:0]  ConnectLen   = 4'd7;
  localparam logic [3:0]  PortCountMax = 4'd15;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  localparam int unsigned TdataW = 24;
  localparam int unsigned TuserW = 6;

  typedef enum logic [1:0] {
    KindNone   = 2'd0,
    KindHttp   = 2'd1,
    KindTunnel = 2'd2
  } kind_e;

  typedef struct packed {
    logic        char_valid;
    logic        char_part;
    logic [7:0]  char_value;
    logic        done_res;
    kind_e       request_kind;
    logic        port_defaulted;
    logic [15:0] default_port_value;
  } res_t;

  typedef struct packed {
    logic two;
    res_t second;
    res_t first;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [7:0] connect_char(logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0: ch = 8'h43;
      3'd1: ch = 8'h4F;
      3'd2: ch = 8'h4E;
      3'd3: ch = 8'h4E;
      3'd4: ch = 8'h45;
      3'd5: ch = 8'h43;
      3'd6: ch = 8'h54;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- sv/http_target_host_port_extractor_unit.sv -----
// ----------------------------------------------------------------------------
// HTTP target extractor
// Streams the target host and port of a request and reports its kind.
// ----------------------------------------------------------------------------
// The slave stream takes one request byte per beat, with tlast on the final
// byte of a message. The master stream gives one result per beat: a host or
// port character, a message summary, or both; tlast marks the last result
// caused by one request byte, and at most two results follow from a byte.
// The configuration channel writes the two default port registers; register
// index 0 is the tunnel default and index 1 the plain default.
// The parser takes a byte in every cycle while its queue of four result
// groups has room. A result is registered in the queue and then in the
// output register; the emitter sends one result per cycle while the
// receiver is ready, a beat for each result. When the receiver stalls, the
// output register holds its beat and the queue absorbs up to four groups
// before tready falls. Reset returns the parser to the start of a message,
// empties the queue and loads the default ports with 443 and 80.
// ----------------------------------------------------------------------------
module http_target_host_port_extractor_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hhpe_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // data_byte
  input  logic [7:0]                    s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // char_value, default_port_value
  output logic [hhpe_pkg::TdataW-1:0]   m_axis_tdata,
  // char_valid, char_part, done_res, request_kind, port_defaulted
  output logic [hhpe_pkg::TuserW-1:0]   m_axis_tuser,
  output logic                          m_axis_tlast
);

  hhpe_pkg::entry_t        entry;
  hhpe_pkg::entry_t        head;
  hhpe_pkg::queue_status_t status;
  logic                    push;
  logic                    pop;
  logic                    accept;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !status.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  hhpe_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .eom_i       (s_axis_tlast),
    .push_o      (push),
    .entry_o     (entry)
  );

  hhpe_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  hhpe_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .status_i      (status),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- sv/hhpe_parser.sv -----
// ----------------------------------------------------------------------------
// Target extractor parser
// Classifies each request byte and forms the up to two results it causes.
// ----------------------------------------------------------------------------
module hhpe_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [hhpe_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          accept_i,
  input  logic [7:0]                    byte_i,
  input  logic                          eom_i,
  output logic                          push_o,
  output hhpe_pkg::entry_t              entry_o
);

  typedef enum logic [3:0] {
    PhPrefix = 4'd0,
    PhSearch = 4'd1,
    PhCSkip  = 4'd2,
    PhCHost  = 4'd3,
    PhCPort  = 4'd4,
    PhHSkip  = 4'd5,
    PhHHost  = 4'd6,
    PhHPort  = 4'd7
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  pos_q, pos_d;
  logic [47:0] recent_q, recent_d;
  logic [7:0]  held_byte_q, held_byte_d;
  logic        held_valid_q, held_valid_d;
  logic [3:0]  count_q, count_d;
  logic        summary_q, summary_d;
  logic [15:0] tunnel_port_q, plain_port_q;

  hhpe_pkg::res_t res [2];
  logic [1:0]     nres;

  always_comb begin
    logic  host_hit;
    logic  done;
    logic  stop;
    logic  idx;
    hhpe_pkg::kind_e kind;
    phase_d      = phase_q;
    pos_d        = pos_q;
    recent_d     = recent_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    count_d      = count_q;
    summary_d    = summary_q;
    res[0]       = '0;
    res[1]       = '0;
    nres         = 2'd0;
    done         = 1'b0;
    stop         = 1'b0;
    idx          = 1'b0;
    kind         = hhpe_pkg::KindNone;
    host_hit     = (byte_i == hhpe_pkg::ChColon) && (recent_q == hhpe_pkg::HostTag);

    if (!summary_q) begin
      unique case (phase_q)
        PhPrefix: begin
          if (pos_q < hhpe_pkg::ConnectLen &&
              byte_i == hhpe_pkg::connect_char(pos_q[2:0])) begin
            pos_d = pos_q + 4'd1;
            if (pos_d == hhpe_pkg::ConnectLen) begin
              phase_d = PhCSkip;
            end
          end else begin
            phase_d = host_hit ? PhHSkip : PhSearch;
          end
          recent_d = {recent_q[39:0], byte_i};
        end
        PhSearch: begin
          if (host_hit) begin
            phase_d = PhHSkip;
          end
          recent_d = {recent_q[39:0], byte_i};
        end
        PhCSkip: begin
          phase_d = PhCHost;
        end
        PhHSkip: begin
          phase_d = PhHHost;
        end
        PhCHost: begin
          if (byte_i == hhpe_pkg::ChColon) begin
            phase_d = PhCPort;
          end else if (byte_i == hhpe_pkg::ChSpace) begin
            done = 1'b1;
          end else begin
            res[0].char_valid = 1'b1;
            res[0].char_value = byte_i;
            nres = 2'd1;
          end
        end
        PhCPort: begin
          if (byte_i == hhpe_pkg::ChSpace) begin
            done = 1'b1;
          end else begin
            res[0].char_valid = 1'b1;
            res[0].char_part  = 1'b1;
            res[0].char_value = byte_i;
            nres = 2'd1;
            if (count_d < hhpe_pkg::PortCountMax) count_d = count_d + 4'd1;
          end
        end
        PhHHost, PhHPort: begin
          if (held_valid_q) begin
            held_valid_d = 1'b0;
            if (byte_i == hhpe_pkg::ChLf) begin
              done = 1'b1;
              stop = 1'b1;
            end else begin
              res[0].char_valid = 1'b1;
              res[0].char_part  = (phase_q == PhHPort);
              res[0].char_value = held_byte_q;
              nres = 2'd1;
              if (phase_q == PhHPort && count_d < hhpe_pkg::PortCountMax) begin
                count_d = count_d + 4'd1;
              end
            end
          end
          if (!stop) begin
            if (phase_q == PhHHost && byte_i == hhpe_pkg::ChColon) begin
              phase_d = PhHPort;
            end else if (byte_i == hhpe_pkg::ChCr) begin
              held_valid_d = 1'b1;
              held_byte_d  = byte_i;
            end else begin
              idx = nres[0];
              res[idx].char_valid = 1'b1;
              res[idx].char_part  = (phase_q == PhHPort);
              res[idx].char_value = byte_i;
              nres = nres + 2'd1;
              if (phase_q == PhHPort && count_d < hhpe_pkg::PortCountMax) begin
                count_d = count_d + 4'd1;
              end
            end
          end
        end
        default: begin
          phase_d = PhSearch;
        end
      endcase

      if (eom_i && !done) begin
        if (held_valid_d) begin
          held_valid_d = 1'b0;
          idx = nres[0];
          res[idx].char_valid = 1'b1;
          res[idx].char_part  = (phase_d == PhHPort);
          res[idx].char_value = held_byte_d;
          nres = nres + 2'd1;
          if (phase_d == PhHPort && count_d < hhpe_pkg::PortCountMax) begin
            count_d = count_d + 4'd1;
          end
        end
        done = 1'b1;
      end

      if (done) begin
        if (phase_d == PhCSkip || phase_d == PhCHost || phase_d == PhCPort) begin
          kind = hhpe_pkg::KindTunnel;
        end else if (phase_d == PhHSkip || phase_d == PhHHost || phase_d == PhHPort) begin
          kind = hhpe_pkg::KindHttp;
        end
        if (nres == 2'd0) begin
          nres = 2'd1;
        end
        idx = (nres == 2'd2);
        res[idx].done_res     = 1'b1;
        res[idx].request_kind = kind;
        if (kind != hhpe_pkg::KindNone && count_d == 4'd0) begin
          res[idx].port_defaulted     = 1'b1;
          res[idx].default_port_value =
              (kind == hhpe_pkg::KindTunnel) ? tunnel_port_q : plain_port_q;
        end
        summary_d = 1'b1;
      end
    end

    if (eom_i) begin
      phase_d      = PhPrefix;
      pos_d        = 4'd0;
      recent_d     = '0;
      held_byte_d  = '0;
      held_valid_d = 1'b0;
      count_d      = 4'd0;
      summary_d    = 1'b0;
    end
  end

  assign push_o         = accept_i && (nres != 2'd0);
  assign entry_o.two    = (nres == 2'd2);
  assign entry_o.first  = res[0];
  assign entry_o.second = res[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhPrefix;
      pos_q         <= 4'd0;
      recent_q      <= '0;
      held_byte_q   <= '0;
      held_valid_q  <= 1'b0;
      count_q       <= 4'd0;
      summary_q     <= 1'b0;
      tunnel_port_q <= hhpe_pkg::TunnelPortReset;
      plain_port_q  <= hhpe_pkg::PlainPortReset;
    end else begin
      if (accept_i) begin
        phase_q      <= phase_d;
        pos_q        <= pos_d;
        recent_q     <= recent_d;
        held_byte_q  <= held_byte_d;
        held_valid_q <= held_valid_d;
        count_q      <= count_d;
        summary_q    <= summary_d;
      end
      if (cfg_valid_i) begin
        if (cfg_addr_i == hhpe_pkg::CfgTunnelPort) tunnel_port_q <= cfg_data_i;
        if (cfg_addr_i == hhpe_pkg::CfgPlainPort)  plain_port_q  <= cfg_data_i;
      end
    end
  end

endmodule

// ----- sv/hhpe_queue.sv -----
// ----------------------------------------------------------------------------
// Target extractor result queue
// Short first-in first-out store of result groups between parser and emitter.
// ----------------------------------------------------------------------------
module hhpe_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  hhpe_pkg::entry_t        entry_i,
  input  logic                    pop_i,
  output hhpe_pkg::entry_t        head_o,
  output hhpe_pkg::queue_status_t status_o
);

  hhpe_pkg::entry_t mem_q [hhpe_pkg::QueueDepth];

  logic [hhpe_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [hhpe_pkg::QueueCntW-1:0] count_q;
  logic                           do_push, do_pop;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == hhpe_pkg::QueueCntW'(hhpe_pkg::QueueDepth));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + hhpe_pkg::QueuePtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + hhpe_pkg::QueuePtrW'(1);
      if (do_push && !do_pop) begin
        count_q <= count_q + hhpe_pkg::QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - hhpe_pkg::QueueCntW'(1);
      end
    end
  end

endmodule

// ----- sv/hhpe_emitter.sv -----
// ----------------------------------------------------------------------------
// Target extractor emitter
// Takes result groups from the queue and sends them one beat at a time.
// ----------------------------------------------------------------------------
module hhpe_emitter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  hhpe_pkg::entry_t               head_i,
  input  hhpe_pkg::queue_status_t        status_i,
  output logic                           pop_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [hhpe_pkg::TdataW-1:0]    m_axis_tdata,
  output logic [hhpe_pkg::TuserW-1:0]    m_axis_tuser,
  output logic                           m_axis_tlast
);

  logic           valid_q;
  logic           sel_q;
  logic           last_q;
  hhpe_pkg::res_t res_q;
  logic           load;
  hhpe_pkg::res_t pick;

  assign load  = (!valid_q || m_axis_tready) && !status_i.empty;
  assign pick  = sel_q ? head_i.second : head_i.first;
  assign pop_o = load && (sel_q || !head_i.two);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        sel_q   <= head_i.two && !sel_q;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= pick;
      last_q <= sel_q || !head_i.two;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {res_q.default_port_value, res_q.char_value};
  assign m_axis_tuser  = {res_q.port_defaulted, res_q.request_kind, res_q.done_res,
                          res_q.char_part, res_q.char_valid};
  assign m_axis_tlast  = last_q;

endmodule

// ----- sv/hhpe_checker.sv -----
// ----------------------------------------------------------------------------
// Target extractor port checker
// Checks the result stream of the target extractor as seen at its ports.
// ----------------------------------------------------------------------------
module hhpe_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [hhpe_pkg::TdataW-1:0] m_axis_tdata,
  input logic [hhpe_pkg::TuserW-1:0] m_axis_tuser,
  input logic                        m_axis_tlast
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("Result beat changed while stalled.");

  a_no_char_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata[7:0] == 8'd0 && !m_axis_tuser[1])
    else $error("Character fields set on a beat without a character.");

  a_no_summary_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tuser[2] |->
      m_axis_tuser[5:3] == 3'd0 && m_axis_tdata[23:8] == 16'd0)
    else $error("Summary fields set on a beat without a summary.");

  a_default_needs_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && m_axis_tuser[5] |->
      m_axis_tuser[4:3] == hhpe_pkg::KindHttp || m_axis_tuser[4:3] == hhpe_pkg::KindTunnel)
    else $error("Default port reported without a target kind.");

  a_summary_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tlast)
    else $error("Summary beat is not the last of its run.");

endmodule

bind http_target_host_port_extractor_unit hhpe_checker u_hhpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
